>>> rtl/core/tpw_pkg.sv
// Package for the trie prefix word replacer: sizes, character codes, item types,
// the layout of one trie row and the matching phase. No dependencies.
`timescale 1ns / 1ps

package tpw_pkg;

    localparam int NODES    = 1024;
    localparam int ALPHABET = 26;

    localparam int NODE_W = $clog2(NODES);
    localparam int IDX_W  = $clog2(ALPHABET);
    localparam int NF_W   = $clog2(NODES + 1);

    localparam logic [7:0] CH_BASE  = 8'h61;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic       mode;
        logic [7:0] ch;
        logic       word_end;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       keep;
        logic       out_last;
        logic       full_res;
    } out_item_t;

    // One memory row per node. The mark bit of a slot says that a dictionary
    // word ends at the child reached through that slot.
    typedef struct packed {
        logic [ALPHABET-1:0]             mark;
        logic [ALPHABET-1:0][NODE_W-1:0] child;
    } row_t;

    typedef enum logic [1:0] {
        PH_MATCHING = 2'd0,
        PH_DROPPING = 2'd1,
        PH_PASSING  = 2'd2
    } match_phase_t;

    typedef struct packed {
        logic [NF_W-1:0]   next_free;
        logic [NODE_W-1:0] insert_cursor;
        logic              insert_failed;
        logic [NODE_W-1:0] match_cursor;
        match_phase_t      match_phase;
    } trie_state_t;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } seq_state_t;

endpackage

>>> rtl/core/tpw_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read.
// Self-contained; used for the trie row store.
`timescale 1ns / 1ps

module tpw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/tpw_update.sv
// Read-modify-write logic for one item: from the item, the cursor state and the
// trie row just read it forms the new state, the row to write back and the result.
// Depends on tpw_pkg.
`timescale 1ns / 1ps

module tpw_update
    import tpw_pkg::*;
(
    input  in_item_t    item,
    input  trie_state_t st,
    input  row_t        row,
    output trie_state_t st_next,
    output row_t        row_new,
    output logic        wr_en,
    output out_item_t   result
);

    logic [7:0]        d;
    logic              is_letter;
    logic [IDX_W-1:0]  idx;
    logic [NODE_W-1:0] rd_child;
    logic              rd_mark;
    logic [NODE_W-1:0] ins_child;
    logic [NODE_W-1:0] ins_cur;
    logic              ins_fail;
    logic              full;
    logic              keep;

    assign d         = item.ch - CH_BASE;
    assign is_letter = (item.ch >= CH_BASE) && (d < 8'(ALPHABET));
    assign idx       = is_letter ? d[IDX_W-1:0] : '0;
    assign rd_child  = row.child[idx];
    assign rd_mark   = row.mark[idx];

    always_comb begin
        st_next   = st;
        row_new   = row;
        wr_en     = 1'b0;
        full      = 1'b0;
        keep      = 1'b1;
        ins_child = rd_child;
        ins_cur   = st.insert_cursor;
        ins_fail  = st.insert_failed;
        result    = '0;

        if (!item.mode) begin
            if (!ins_fail) begin
                if (is_letter) begin
                    if (rd_child == '0) begin
                        if (st.next_free < NF_W'(NODES)) begin
                            ins_child          = st.next_free[NODE_W-1:0];
                            st_next.next_free  = st.next_free + 1'b1;
                            row_new.child[idx] = ins_child;
                            wr_en              = 1'b1;
                        end else begin
                            full     = 1'b1;
                            ins_fail = 1'b1;
                        end
                    end
                    if (!ins_fail) begin
                        ins_cur = ins_child;
                    end
                end else begin
                    ins_fail = 1'b1;
                end
            end
            if (item.word_end) begin
                // A word can only end cleanly on the character just inserted, so
                // the mark goes on the slot of this row that leads to it.
                if (!ins_fail) begin
                    row_new.mark[idx] = 1'b1;
                    wr_en             = 1'b1;
                end
                ins_cur  = '0;
                ins_fail = 1'b0;
            end
            st_next.insert_cursor = ins_cur;
            st_next.insert_failed = ins_fail;
            result.full_res       = full;
        end else begin
            if (item.ch == CH_SPACE) begin
                st_next.match_cursor = '0;
                st_next.match_phase  = PH_MATCHING;
            end else begin
                case (st.match_phase)
                    PH_MATCHING: begin
                        if (is_letter && (rd_child != '0)) begin
                            st_next.match_cursor = rd_child;
                            if (rd_mark) begin
                                st_next.match_phase = PH_DROPPING;
                            end
                        end else begin
                            st_next.match_phase = PH_PASSING;
                        end
                    end
                    PH_DROPPING: begin
                        keep = 1'b0;
                    end
                    default: begin
                        keep = 1'b1;
                    end
                endcase
            end
            if (item.last) begin
                st_next.match_cursor = '0;
                st_next.match_phase  = PH_MATCHING;
            end
            result.out_char = item.ch;
            result.keep     = keep;
            result.out_last = item.last;
        end
    end

endmodule

>>> rtl/core/trie_prefix_word_replacer.sv
// Trie prefix word replacer: dictionary items (mode 0) build a trie of roots in one
// row-wide memory, sentence items (mode 1) are matched against it. For every item
// the node's row is read from the memory in the cycle the item is accepted, and the
// next cycle updates the cursors, writes the row back when an insert changed it and
// loads the result register. A new item is accepted only in the idle state, once the
// last item is through, and when the result register is empty or being taken. After
// reset a clearing pass writes every row to zero, one row a cycle; no item is accepted
// during it. Depends on tpw_pkg, tpw_update and tpw_ram.
`timescale 1ns / 1ps

module trie_prefix_word_replacer
    import tpw_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam trie_state_t ST_RESET = '{
        next_free:     NF_W'(1),
        insert_cursor: '0,
        insert_failed: 1'b0,
        match_cursor:  '0,
        match_phase:   PH_MATCHING
    };

    seq_state_t        state_reg, state_next;
    logic [NODE_W-1:0] clr_cnt_reg, clr_cnt_next;
    trie_state_t       trie_reg, trie_next;
    in_item_t          item_reg;
    logic [NODE_W-1:0] addr_reg;
    out_item_t         out_reg;
    logic              out_valid_reg, out_valid_next;

    logic              accept;
    logic [NODE_W-1:0] rd_addr;
    logic              ram_we;
    logic [NODE_W-1:0] ram_waddr;
    row_t              ram_wdata;
    row_t              rd_row;
    row_t              upd_row;
    logic              upd_wr_en;
    trie_state_t       upd_state;
    out_item_t         upd_result;

    assign s_ready = (state_reg == S_IDLE) && (!out_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign rd_addr = s_data.mode ? trie_reg.match_cursor : trie_reg.insert_cursor;

    tpw_ram #(
        .WIDTH($bits(row_t)),
        .DEPTH(NODES)
    ) u_rows (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (accept),
        .raddr(rd_addr),
        .rdata(rd_row)
    );

    tpw_update u_update (
        .item   (item_reg),
        .st     (trie_reg),
        .row    (rd_row),
        .st_next(upd_state),
        .row_new(upd_row),
        .wr_en  (upd_wr_en),
        .result (upd_result)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = upd_row;
        case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            S_EXEC: begin
                ram_we = upd_wr_en;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        trie_next      = trie_reg;
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == NODE_W'(NODES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                trie_next      = upd_state;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            trie_reg      <= ST_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            trie_reg      <= trie_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
            addr_reg <= rd_addr;
        end
        if (state_reg == S_EXEC) begin
            out_reg <= upd_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

>>> dv/tb.sv
// Self-checking testbench for trie_prefix_word_replacer: a directed table, then random
// dictionary words, sentences and noise, checked against a behavioural trie model (typed
// table rows against the table). Depends on tpw_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb;
    import tpw_pkg::*;

    localparam logic MODE_DICT = 1'b0;
    localparam logic MODE_SENT = 1'b1;
    localparam int   TIMEOUT_NS = 3_000_000;
    localparam int   MAX_PRINTS = 40;

    typedef struct packed {
        in_item_t  stim;
        logic      typed;
        out_item_t want;
    } dir_row_t;

    // Directed rows: sentence, roots "cat", "ba", "az", abandoned inserts, sentences, root "q", sentences.
    localparam int DIR_ROWS = 26;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{'{MODE_SENT, "c", 1'b0, 1'b0}, 1'b1, '{"c", 1'b1, 1'b0, 1'b0}},
        '{'{MODE_SENT, " ", 1'b1, 1'b1}, 1'b1, '{" ", 1'b1, 1'b1, 1'b0}},
        '{'{MODE_DICT, "c", 1'b0, 1'b0}, 1'b1, '0},
        '{'{MODE_DICT, "a", 1'b0, 1'b1}, 1'b1, '0},
        '{'{MODE_DICT, "t", 1'b1, 1'b0}, 1'b1, '0},
        '{'{MODE_DICT, "b", 1'b0, 1'b0}, 1'b1, '0},
        '{'{MODE_DICT, "a", 1'b1, 1'b0}, 1'b1, '0},
        '{'{MODE_DICT, "a", 1'b0, 1'b0}, 1'b1, '0},
        '{'{MODE_DICT, "z", 1'b1, 1'b0}, 1'b1, '0},
        '{'{MODE_DICT, "x", 1'b0, 1'b0}, 1'b1, '0},
        '{'{MODE_DICT, 8'h7B, 1'b0, 1'b0}, 1'b1, '0},
        '{'{MODE_DICT, "y", 1'b1, 1'b0}, 1'b1, '0},
        '{'{MODE_DICT, 8'hFF, 1'b1, 1'b1}, 1'b1, '0},
        '{'{MODE_SENT, "c", 1'b0, 1'b0}, 1'b0, '0},
        '{'{MODE_SENT, "a", 1'b0, 1'b0}, 1'b0, '0},
        '{'{MODE_SENT, "t", 1'b0, 1'b0}, 1'b0, '0},
        '{'{MODE_SENT, "t", 1'b1, 1'b0}, 1'b0, '0},
        '{'{MODE_SENT, " ", 1'b0, 1'b0}, 1'b0, '0},
        '{'{MODE_SENT, 8'h60, 1'b0, 1'b0}, 1'b0, '0},
        '{'{MODE_SENT, "b", 1'b0, 1'b0}, 1'b0, '0},
        '{'{MODE_SENT, " ", 1'b0, 1'b0}, 1'b0, '0},
        '{'{MODE_SENT, "a", 1'b0, 1'b0}, 1'b0, '0},
        '{'{MODE_DICT, "q", 1'b1, 1'b0}, 1'b1, '0},
        '{'{MODE_SENT, "z", 1'b0, 1'b0}, 1'b0, '0},
        '{'{MODE_SENT, 8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{MODE_SENT, 8'hFF, 1'b0, 1'b1}, 1'b0, '0}
    };

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int sent_count   = 0;
    int result_count = 0;
    int fail_count   = 0;

    out_item_t expected_q [$];
    string     dict_words [$];

    // Behavioural copy of the trie and both cursors.
    bit [NODE_W-1:0] trie_child [NODES][ALPHABET];
    bit              trie_mark  [NODES];
    int              free_node   = 1;
    int              ins_cursor  = 0;
    bit              ins_failed  = 1'b0;
    int              scan_cursor = 0;
    match_phase_t    scan_phase  = PH_MATCHING;

    trie_prefix_word_replacer u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int letter_of(input logic [7:0] c);
        if (c >= CH_BASE && (c - CH_BASE) < ALPHABET) begin
            return int'(c - CH_BASE);
        end
        return -1;
    endfunction

    // Advances the trie model by one item and returns the result it gives.
    function automatic out_item_t trie_outcome(input in_item_t it);
        out_item_t res;
        int        li;
        int        nxt;
        res = '0;
        li  = letter_of(it.ch);
        if (it.mode == MODE_DICT) begin
            if (!ins_failed) begin
                if (li < 0) begin
                    ins_failed = 1'b1;
                end else begin
                    nxt = trie_child[ins_cursor][li];
                    if (nxt == 0) begin
                        if (free_node < NODES) begin
                            nxt = free_node;
                            free_node++;
                            trie_child[ins_cursor][li] = nxt[NODE_W-1:0];
                        end else begin
                            res.full_res = 1'b1;
                            ins_failed   = 1'b1;
                        end
                    end
                    if (!ins_failed) ins_cursor = nxt;
                end
            end
            if (it.word_end) begin
                if (!ins_failed) trie_mark[ins_cursor] = 1'b1;
                ins_cursor = 0;
                ins_failed = 1'b0;
            end
        end else begin
            res.out_char = it.ch;
            res.out_last = it.last;
            res.keep     = 1'b1;
            if (it.ch == CH_SPACE) begin
                scan_cursor = 0;
                scan_phase  = PH_MATCHING;
            end else if (scan_phase == PH_MATCHING) begin
                nxt = (li >= 0) ? int'(trie_child[scan_cursor][li]) : 0;
                if (nxt != 0) begin
                    scan_cursor = nxt;
                    if (trie_mark[scan_cursor]) scan_phase = PH_DROPPING;
                end else begin
                    scan_phase = PH_PASSING;
                end
            end else if (scan_phase == PH_DROPPING) begin
                res.keep = 1'b0;
            end
            if (it.last) begin
                scan_cursor = 0;
                scan_phase  = PH_MATCHING;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < MAX_PRINTS) begin
            $display("MISMATCH at result %0d: %s got 0x%0h, expected 0x%0h",
                     result_count, what, got, want);
        end
        fail_count++;
    endtask

    // Drives one item and waits for its acceptance; valid is left high afterwards so that
    // back-to-back items need no extra edge.
    task automatic send_item(input in_item_t it, input logic typed = 1'b0,
                             input out_item_t want = '0);
        out_item_t calc;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        calc = trie_outcome(it);
        expected_q.push_back(typed ? want : calc);
        sent_count++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_q.size() != 0);
    endtask

    function automatic in_item_t mk_item(input logic mode, input logic [7:0] c,
                                         input logic we, input logic lst);
        in_item_t it;
        it.mode     = mode;
        it.ch       = c;
        it.word_end = we;
        it.last     = lst;
        return it;
    endfunction

    // Unless wide, letters are mostly drawn from the first six so that words share prefixes.
    function automatic string new_word(input int lo, input int hi, input bit wide);
        string w;
        int    n;
        bit    any;
        w   = "";
        n   = $urandom_range(hi, lo);
        any = wide || ($urandom_range(3) == 0);
        repeat (n) begin
            w = $sformatf("%s%c", w,
                          CH_BASE + (any ? $urandom_range(ALPHABET - 1) : $urandom_range(5)));
        end
        return w;
    endfunction

    task automatic send_dict_word(input string w, input bit corrupt);
        if (corrupt) w.putc($urandom_range(w.len() - 1), 8'($urandom_range(255, 1)));
        for (int j = 0; j < w.len(); j++) begin
            send_item(mk_item(MODE_DICT, w[j], j == w.len() - 1,
                              1'($urandom_range(1))));
        end
        if (!corrupt) begin
            dict_words.push_back(w);
            if (dict_words.size() > 48) void'(dict_words.pop_front());
        end
    endtask

    task automatic send_sentence();
        string s;
        string w;
        int    n_words;
        s       = "";
        n_words = $urandom_range(4, 1);
        for (int i = 0; i < n_words; i++) begin
            if (dict_words.size() != 0 && $urandom_range(9) < 7) begin
                w = dict_words[$urandom_range(dict_words.size() - 1)];
                if ($urandom_range(1)) w = w.substr(0, $urandom_range(w.len() - 1));
                else w = {w, new_word(0, 3, 1'b0)};
            end else begin
                w = new_word(1, 6, 1'b0);
            end
            if ($urandom_range(6) == 0) begin
                w.putc($urandom_range(w.len() - 1), 8'($urandom_range(255, 1)));
            end
            s = {s, w};
            if (i != n_words - 1) begin
                if ($urandom_range(7) == 0) s = {s, "  "};
                else s = {s, " "};
            end
        end
        if ($urandom_range(1)) s = {s, " "};
        for (int j = 0; j < s.len(); j++) begin
            // A dictionary word slipped in between the items of a sentence.
            if ($urandom_range(24) == 0) send_dict_word(new_word(1, 5, 1'b0), 1'b0);
            send_item(mk_item(MODE_SENT, s[j], 1'($urandom_range(1)), j == s.len() - 1));
        end
    endtask

    task automatic run_random(input int n);
        logic [$bits(in_item_t)-1:0] raw;
        logic [31:0]                 rnd;
        int stop_at;
        int r;
        stop_at = sent_count + n;
        while (sent_count < stop_at) begin
            r = $urandom_range(99);
            if (r < 3) begin
                wait_drained();
            end else if (r < 30) begin
                send_dict_word(new_word(1, 6, 1'b0), $urandom_range(9) == 0);
            end else if (r < 88) begin
                send_sentence();
            end else begin
                repeat ($urandom_range(3, 1)) begin
                    rnd = $urandom;
                    raw = rnd[$bits(in_item_t)-1:0];
                    send_item(in_item_t'(raw));
                end
            end
        end
    endtask

    always @(posedge aclk) begin : result_side
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", int'(m_data), 0);
            end else begin
                want = expected_q.pop_front();
                if (m_data.out_char !== want.out_char) begin
                    report_mismatch("out_char", int'(m_data.out_char), int'(want.out_char));
                end
                if (m_data.keep !== want.keep) begin
                    report_mismatch("keep", int'(m_data.keep), int'(want.keep));
                end
                if (m_data.out_last !== want.out_last) begin
                    report_mismatch("out_last", int'(m_data.out_last), int'(want.out_last));
                end
                if (m_data.full_res !== want.full_res) begin
                    report_mismatch("full_res", int'(m_data.full_res), int'(want.full_res));
                end
            end
        end
        m_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        tx_idle_pct = 23;
        rx_idle_pct = 71;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_item(DIR_TABLE[i].stim, DIR_TABLE[i].typed, DIR_TABLE[i].want);
        end
        wait_drained();
        run_random(50);
        wait_drained();

        tx_idle_pct = 71;
        rx_idle_pct = 23;
        run_random(50);
        wait_drained();

        // No idling from here on. Long words over the whole alphabet use up the node
        // pool, and four more words then run into the full condition.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        while (free_node < NODES) send_dict_word(new_word(20, 30, 1'b1), 1'b0);
        repeat (4) send_dict_word(new_word(10, 20, 1'b1), 1'b0);
        run_random(50);
        wait_drained();

        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
